@@ src/smmm_pkg.sv @@
// Shared types and constants for the sample-set statistics block.
// No dependencies; compile before every other file of the block.
package smmm_pkg;

    // Width of the sensor number carried in each result
    localparam int SENSOR_W = 8;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_DRAIN,
        ST_OUT
    } smmm_state_t;

    // Commands broadcast from the sequencer to every sorting cell
    typedef struct packed {
        logic insert;   // place the broadcast sample into the sorted chain
        logic shift;    // move every cell one place towards cell 0
    } cell_ctrl_t;

endpackage

@@ src/smmm_if.sv @@
// Valid/ready channels of the sample-set statistics block.
// Depends on smmm_pkg for the sensor number width.
interface smmm_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
    logic                          last_sensor;

    modport source (output valid, sample, last_sample, last_sensor, input ready);
    modport sink   (input valid, sample, last_sample, last_sensor, output ready);
endinterface

interface smmm_out_if import smmm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = 11
) ();
    logic                          valid;
    logic                          ready;
    logic        [SENSOR_W-1:0]    sensor_number;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic signed [SAMPLE_BITS:0]   median_doubled;
    logic        [CNT_W-1:0]       sample_count;
    logic                          overflowed;

    modport source (output valid, sensor_number, maximum, minimum, mean,
                    median_doubled, sample_count, overflowed, input ready);
    modport sink   (input valid, sensor_number, maximum, minimum, mean,
                    median_doubled, sample_count, overflowed, output ready);
endinterface

@@ src/smmm_cell.sv @@
// One cell of the insertion-sorting chain: holds one sample and its valid bit.
// Depends on smmm_pkg (cell_ctrl_t).
module smmm_cell import smmm_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] prev_value,
    input  logic                          prev_valid,
    input  logic                          prev_take,
    input  logic signed [SAMPLE_BITS-1:0] next_value,
    input  logic                          next_valid,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic                          valid,
    output logic                          take
);

    logic signed [SAMPLE_BITS-1:0] value_reg, value_next;
    logic                          valid_reg, valid_next;

    // This cell moves on insert when it is empty or holds a larger sample
    assign take = !valid_reg || (value_reg > x);

    // Insert: take the lower neighbour's sample if it moves too, else the new one.
    // Shift: pull from the upper neighbour.
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert && take)
        begin
            if (prev_take)
            begin
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else
            begin
                value_next = x;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    // Valid bit is control state; the sample itself needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

@@ src/smmm_div.sv @@
// Iterative restoring divider: signed dividend by unsigned divisor, one
// quotient bit per cycle, truncating toward zero. No package dependency.
module smmm_div #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  den_reg, den_next;
    logic                  neg_reg, neg_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fit;
    logic [DIVIDEND_W-1:0] magnitude;

    // Magnitude of the dividend, taken as unsigned so the most negative value fits
    assign magnitude = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fit       = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = magnitude;
            rem_next  = '0;
            den_next  = divisor;
            neg_next  = dividend[DIVIDEND_W-1];
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fit};
            rem_next  = fit ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

@@ src/sample_set_min_max_mean_median.sv @@
// Sample-set statistics: maximum, minimum, mean and doubled median per sensor run.
// Depends on smmm_pkg, smmm_if, smmm_cell and smmm_div.
// Throughput: one sample request per cycle while a run is collected.
// After the last sample the block drains the sorting chain while the bit-serial mean
// divider runs; once both are done the result waits for the receiver.
// Reset clears all control state and every cell's valid bit at once; no clearing pass.
module sample_set_min_max_mean_median import smmm_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    smmm_in_if.sink     sample_in,
    smmm_out_if.source  result_out
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    smmm_state_t state_reg, state_next;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic                          ovf_reg, ovf_next;
    logic [SENSOR_W-1:0]           run_reg, run_next;
    logic                          set_end_reg, set_end_next;
    logic [CNT_W-1:0]              drain_idx_reg, drain_idx_next;
    logic                          drain_done_reg, drain_done_next;
    logic signed [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic signed [SAMPLE_BITS-1:0] hi_reg, hi_next;

    logic                          in_acc;
    logic                          out_acc;
    logic                          keep;
    logic                          first;
    logic [CNT_W-1:0]              mid_lo;
    logic [CNT_W-1:0]              mid_hi;
    logic                          div_start;
    logic                          div_done;
    logic signed [SUM_W-1:0]       div_quo;
    cell_ctrl_t                    ctrl;

    logic signed [SAMPLE_BITS-1:0] cell_value [MAX_SAMPLES];
    logic                          cell_valid [MAX_SAMPLES];
    logic                          cell_take  [MAX_SAMPLES];

    assign in_acc  = sample_in.valid && sample_in.ready;
    assign out_acc = result_out.valid && result_out.ready;
    assign keep    = count_reg != CNT_W'(MAX_SAMPLES);
    assign first   = count_reg == '0;
    assign mid_lo  = (count_reg - 1'b1) >> 1;
    assign mid_hi  = count_reg >> 1;

    // Sorting chain: cell 0 holds the smallest sample
    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] prev_value;
        logic                          prev_valid;
        logic                          prev_take;
        logic signed [SAMPLE_BITS-1:0] next_value;
        logic                          next_valid;

        if (i == 0)
        begin : g_first
            assign prev_value = '0;
            assign prev_valid = 1'b0;
            assign prev_take  = 1'b0;
        end
        else
        begin : g_inner_lo
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_take  = cell_take[i-1];
        end

        if (i == MAX_SAMPLES - 1)
        begin : g_last
            assign next_value = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_inner_hi
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
        end

        smmm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .x          (sample_in.sample),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_take  (prev_take),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .take       (cell_take[i])
        );
    end

    // Mean divider, started on the first drain cycle
    smmm_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc && sample_in.last_sample)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done_reg && div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Handshakes and chain commands
    always_comb
    begin
        sample_in.ready  = 1'b0;
        result_out.valid = 1'b0;
        ctrl.insert      = 1'b0;
        ctrl.shift       = 1'b0;
        div_start        = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                sample_in.ready = 1'b1;
                ctrl.insert     = sample_in.valid && keep;
            end
            ST_DRAIN:
            begin
                ctrl.shift = !drain_done_reg;
                div_start  = !drain_done_reg && (drain_idx_reg == '0);
            end
            ST_OUT:
            begin
                result_out.valid = 1'b1;
            end
            default:
            begin
                sample_in.ready = 1'b0;
            end
        endcase
    end

    // Running statistics, drain counter and median capture
    always_comb
    begin
        count_next      = count_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        sum_next        = sum_reg;
        ovf_next        = ovf_reg;
        run_next        = run_reg;
        set_end_next    = set_end_reg;
        drain_idx_next  = drain_idx_reg;
        drain_done_next = drain_done_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;

        if (in_acc)
        begin
            if (keep)
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(sample_in.sample);
                if (first || (sample_in.sample > max_reg))
                begin
                    max_next = sample_in.sample;
                end
                if (first || (sample_in.sample < min_reg))
                begin
                    min_next = sample_in.sample;
                end
            end
            else
            begin
                ovf_next = 1'b1;
            end
            set_end_next = sample_in.last_sensor;
        end

        // Cell 0 presents the samples in ascending order while draining
        if (ctrl.shift)
        begin
            if (drain_idx_reg == mid_lo)
            begin
                lo_next = cell_value[0];
            end
            if (drain_idx_reg == mid_hi)
            begin
                hi_next = cell_value[0];
            end
            drain_idx_next = drain_idx_reg + 1'b1;
            if (drain_idx_reg == count_reg - 1'b1)
            begin
                drain_done_next = 1'b1;
            end
        end

        // Result taken: advance the sensor number (zero after a set's end) and clear the run
        if (out_acc)
        begin
            run_next        = set_end_reg ? '0 : run_reg + 1'b1;
            count_next      = '0;
            max_next        = '0;
            min_next        = '0;
            sum_next        = '0;
            ovf_next        = 1'b0;
            drain_idx_next  = '0;
            drain_done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            count_reg      <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            run_reg        <= '0;
            set_end_reg    <= 1'b0;
            drain_idx_reg  <= '0;
            drain_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            max_reg        <= max_next;
            min_reg        <= min_next;
            sum_reg        <= sum_next;
            ovf_reg        <= ovf_next;
            run_reg        <= run_next;
            set_end_reg    <= set_end_next;
            drain_idx_reg  <= drain_idx_next;
            drain_done_reg <= drain_done_next;
        end
    end

    // Median samples are payload only
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    // Result payload
    assign result_out.sensor_number  = run_reg;
    assign result_out.maximum        = max_reg;
    assign result_out.minimum        = min_reg;
    assign result_out.mean           = div_quo[SAMPLE_BITS-1:0];
    assign result_out.median_doubled = (SAMPLE_BITS + 1)'(lo_reg) + (SAMPLE_BITS + 1)'(hi_reg);
    assign result_out.sample_count   = count_reg;
    assign result_out.overflowed     = ovf_reg;

endmodule

@@ tb/sv/tb_sample_set_min_max_mean_median.sv @@
`timescale 1ns / 100ps
// Testbench for sample_set_min_max_mean_median: per-run max, min, mean and doubled median.
// Depends on smmm_pkg, smmm_if and the block's RTL; self-checking against its own predictor.
module tb_sample_set_min_max_mean_median import smmm_pkg::*; ();

    localparam int SAMPLE_W       = 16;
    localparam int COUNT_W        = 11;
    localparam int CAPACITY       = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_TAIL     = 1100;
    localparam int HOLD_OFF       = 400;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [SENSOR_W-1:0]       sensor_number;
        logic signed [SAMPLE_W-1:0] maximum;
        logic signed [SAMPLE_W-1:0] minimum;
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W:0]   median_doubled;
        logic [COUNT_W-1:0]         sample_count;
        logic                       overflowed;
    } run_stats_t;

    typedef struct {
        sample_t    sample;
        bit         last_sample;
        bit         last_sensor;
        bit         typed;
        run_stats_t want;
    } request_row_t;

    logic clk;
    logic rst_n;

    smmm_in_if  #(.SAMPLE_BITS(SAMPLE_W)) sample_in ();
    smmm_out_if #(.SAMPLE_BITS(SAMPLE_W), .CNT_W(COUNT_W)) result_out ();

    sample_set_min_max_mean_median #(
        .MAX_SAMPLES(CAPACITY),
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .result_out (result_out)
    );

    // Predictor state: one run in progress
    int         sorted_run[$];
    sample_t    run_max;
    sample_t    run_min;
    longint     run_sum;
    int         run_kept;
    bit         run_dropped;
    logic [SENSOR_W-1:0] run_number;

    run_stats_t pending_stats[$];
    int         mismatch_count;
    int         quiet_cycles;
    int         src_idle_pct;
    int         snk_idle_pct;
    int         hold_off_left;

    // Directed requests; expected values typed in where obvious
    request_row_t directed_rows[22] = '{
        '{16'sh7FFF, 1'b1, 1'b0, 1'b1,
          '{8'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 17'sh0FFFE, 11'd1, 1'b0}},
        '{16'sh8000, 1'b1, 1'b0, 1'b1,
          '{8'd1, 16'sh8000, 16'sh8000, 16'sh8000, 17'sh10000, 11'd1, 1'b0}},
        '{16'sh7FFF, 1'b0, 1'b0, 1'b0, '0},
        // extremes together; sum -1 truncates to a zero mean; closes the set
        '{16'sh8000, 1'b1, 1'b1, 1'b1,
          '{8'd2, 16'sh7FFF, 16'sh8000, 16'sh0000, 17'sh1FFFF, 11'd2, 1'b0}},
        // set flag without last_sample is ignored
        '{16'sd5,    1'b0, 1'b1, 1'b0, '0},
        '{-16'sd3,   1'b0, 1'b0, 1'b0, '0},
        '{16'sd7,    1'b1, 1'b0, 1'b0, '0},
        // negative mean truncates towards zero
        '{-16'sd7,   1'b0, 1'b0, 1'b0, '0},
        '{-16'sd2,   1'b1, 1'b0, 1'b1,
          '{8'd1, -16'sd2, -16'sd7, -16'sd4, -17'sd9, 11'd2, 1'b0}},
        '{16'sd10,   1'b0, 1'b0, 1'b0, '0},
        '{-16'sd20,  1'b0, 1'b0, 1'b0, '0},
        '{16'sd30,   1'b0, 1'b0, 1'b0, '0},
        '{16'sd0,    1'b0, 1'b0, 1'b0, '0},
        '{-16'sd5,   1'b1, 1'b0, 1'b0, '0},
        // equal samples
        '{16'sd4,    1'b0, 1'b0, 1'b0, '0},
        '{16'sd4,    1'b0, 1'b0, 1'b0, '0},
        '{16'sd4,    1'b0, 1'b0, 1'b0, '0},
        '{16'sd4,    1'b1, 1'b1, 1'b0, '0},
        '{16'sh5555, 1'b0, 1'b0, 1'b0, '0},
        '{16'shAAAA, 1'b0, 1'b0, 1'b0, '0},
        '{16'sd0,    1'b1, 1'b0, 1'b0, '0},
        '{16'sd0,    1'b1, 1'b1, 1'b1,
          '{8'd1, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 11'd1, 1'b0}}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run predictor: returns 1 when the request closes a run
    function automatic bit predict_run_stats(input sample_t s, input bit last,
                                             input bit last_set, output run_stats_t res);
        int     pos;
        int     n;
        longint med2;
        longint avg;
        res = '0;
        if (run_kept >= CAPACITY)
            run_dropped = 1'b1;
        else
        begin
            if (run_kept == 0)
            begin
                run_max = s;
                run_min = s;
            end
            else
            begin
                if (s > run_max) run_max = s;
                if (s < run_min) run_min = s;
            end
            run_sum += longint'(s);
            pos = 0;
            while (pos < sorted_run.size() && sorted_run[pos] <= int'(s))
                pos++;
            sorted_run.insert(pos, int'(s));
            run_kept++;
        end
        if (!last)
            return 1'b0;
        n = run_kept;
        avg = run_sum / longint'(n);
        if (n % 2 == 1)
            med2 = 2 * longint'(sorted_run[n / 2]);
        else
            med2 = longint'(sorted_run[n / 2 - 1]) + longint'(sorted_run[n / 2]);
        res.sensor_number  = run_number;
        res.maximum        = run_max;
        res.minimum        = run_min;
        res.mean           = avg[SAMPLE_W-1:0];
        res.median_doubled = med2[SAMPLE_W:0];
        res.sample_count   = n[COUNT_W-1:0];
        res.overflowed     = run_dropped;
        run_number  = last_set ? '0 : run_number + 1'b1;
        run_max     = '0;
        run_min     = '0;
        run_sum     = 0;
        run_kept    = 0;
        run_dropped = 1'b0;
        sorted_run.delete();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // Random sample: extremes, a narrow band for duplicates, or the full range
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 16'sh7FFF;
        if (pick == 1) return 16'sh8000;
        if (pick <= 3) return sample_t'($urandom_range(16)) - 16'sd8;
        return sample_t'($urandom);
    endfunction

    // Offer one request; entered and left at a falling edge
    task automatic send_request(input sample_t s, input bit last, input bit last_set,
                                input bit typed, input run_stats_t typed_want);
        run_stats_t res;
        run_stats_t entry;
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_in.valid <= 1'b0;
            @(negedge clk);
        end
        sample_in.valid       <= 1'b1;
        sample_in.sample      <= s;
        sample_in.last_sample <= last;
        sample_in.last_sensor <= last_set;
        do
            @(posedge clk);
        while (!sample_in.ready);
        if (predict_run_stats(s, last, last_set, res))
        begin
            entry = typed ? typed_want : res;
            pending_stats.insert(pending_stats.size(), entry);
        end
        @(negedge clk);
    endtask

    // Stop offering until every expected result has been taken
    task automatic wait_results_drained();
        sample_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_stats.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Well-formed runs with random content, some stray set flags as noise
    task automatic random_runs(input int budget, input bit set_ends, input bit short_runs);
        int sent;
        int len;
        bit set_flag;
        sent = 0;
        while (sent < budget)
        begin
            if (short_runs)
                len = ($urandom_range(3) == 0) ? 2 : 1;
            else if ($urandom_range(7) == 0)
                len = $urandom_range(40, 7);
            else
                len = $urandom_range(6, 1);
            for (int i = 0; i < len - 1; i++)
                send_request(random_sample(), 1'b0, $urandom_range(15) == 0, 1'b0, '0);
            set_flag = set_ends && ($urandom_range(7) == 0);
            send_request(random_sample(), 1'b1, set_flag, 1'b0, '0);
            sent += len;
        end
    endtask

    // Receiver: random ready, or a counted hold-off
    initial
    begin
        result_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                result_out.ready <= 1'b0;
                hold_off_left--;
            end
            else
                result_out.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Result checker and activity counter
    always @(posedge clk)
    begin : result_monitor
        run_stats_t got;
        run_stats_t want;
        if ((sample_in.valid && sample_in.ready) || (result_out.valid && result_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (result_out.valid && result_out.ready)
        begin
            got.sensor_number  = result_out.sensor_number;
            got.maximum        = result_out.maximum;
            got.minimum        = result_out.minimum;
            got.mean           = result_out.mean;
            got.median_doubled = result_out.median_doubled;
            got.sample_count   = result_out.sample_count;
            got.overflowed     = result_out.overflowed;
            if (pending_stats.size() == 0)
                report_mismatch("unexpected result, sensor", int'(got.sensor_number), -1);
            else
            begin
                want = pending_stats.pop_front();
                if (got.sensor_number !== want.sensor_number)
                    report_mismatch("sensor_number", int'(got.sensor_number),
                                    int'(want.sensor_number));
                if (got.maximum !== want.maximum)
                    report_mismatch("maximum", int'(got.maximum), int'(want.maximum));
                if (got.minimum !== want.minimum)
                    report_mismatch("minimum", int'(got.minimum), int'(want.minimum));
                if (got.mean !== want.mean)
                    report_mismatch("mean", int'(got.mean), int'(want.mean));
                if (got.median_doubled !== want.median_doubled)
                    report_mismatch("median_doubled", int'(got.median_doubled),
                                    int'(want.median_doubled));
                if (got.sample_count !== want.sample_count)
                    report_mismatch("sample_count", int'(got.sample_count),
                                    int'(want.sample_count));
                if (got.overflowed !== want.overflowed)
                    report_mismatch("overflowed", int'(got.overflowed), int'(want.overflowed));
            end
        end
    end

    // Watchdog: too long with no request moving on either side
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("sample_set_min_max_mean_median verification failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        rst_n                 = 1'b0;
        sample_in.valid       = 1'b0;
        sample_in.sample      = '0;
        sample_in.last_sample = 1'b0;
        sample_in.last_sensor = 1'b0;
        mismatch_count        = 0;
        quiet_cycles          = 0;
        hold_off_left         = 0;
        src_idle_pct          = 35;
        snk_idle_pct          = 80;
        run_max               = '0;
        run_min               = '0;
        run_sum               = 0;
        run_kept              = 0;
        run_dropped           = 1'b0;
        run_number            = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        foreach (directed_rows[i])
            send_request(directed_rows[i].sample, directed_rows[i].last_sample,
                         directed_rows[i].last_sensor, directed_rows[i].typed,
                         directed_rows[i].want);

        // Sender sparse, receiver mostly stalled; pause halfway until drained
        random_runs(12, 1'b1, 1'b0);
        wait_results_drained();
        random_runs(12, 1'b1, 1'b0);

        // Sender mostly idle, receiver sparse
        src_idle_pct = 80;
        snk_idle_pct = 35;
        random_runs(16, 1'b1, 1'b0);

        // No idling; long receiver hold-off fills the block and stalls the input
        src_idle_pct = 0;
        snk_idle_pct = 0;
        @(posedge clk);
        hold_off_left = HOLD_OFF;
        @(negedge clk);
        random_runs(20, 1'b0, 1'b1);

        // Store full: two samples past capacity, both dropped
        for (int i = 0; i < CAPACITY + 1; i++)
            send_request(random_sample(), 1'b0, 1'b0, 1'b0, '0);
        send_request(random_sample(), 1'b1, 1'b1, 1'b0, '0);

        wait_results_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (pending_stats.size() != 0)
            report_mismatch("results never seen", pending_stats.size(), 0);
        if (mismatch_count == 0)
            $display("sample_set_min_max_mean_median verification clean");
        else
            $display("sample_set_min_max_mean_median verification failed");
        $finish;
    end

endmodule
